>>> hdl/terrain_slope_aspect_defines.svh
// Assertion helpers for the checker file.
`ifndef TERRAIN_SLOPE_ASPECT_DEFINES_SVH
`define TERRAIN_SLOPE_ASPECT_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is asserted.
`define TSA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("terrain_slope_aspect: assertion failed");

// Property checked on every rising edge, reset included.
`define TSA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("terrain_slope_aspect: assertion failed");

`endif

>>> hdl/tsa_pkg.sv
package tsa_pkg;

  localparam int unsigned ELEV_WIDTH_DEF = 16;
  localparam int unsigned COEF_WIDTH_DEF = 7;
  localparam int unsigned NTAPS          = 9;

  localparam int unsigned KER_W      = 63;
  localparam int unsigned RES_W      = 24;
  localparam int unsigned SM_W       = 8;
  localparam int unsigned CFG_DATA_W = 63;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned ITERS   = 24;
  localparam int unsigned DP_W    = 62;   // CORDIC x and y
  localparam int unsigned ZW      = 34;   // CORDIC angle, Q.24 degrees
  localparam int unsigned AW      = 36;   // aspect arithmetic, Q.24 degrees
  localparam int unsigned MANT_W  = 59;   // mantissas normalised to a leading one at bit 58
  localparam int unsigned MANT_MSB = 58;
  localparam int unsigned NORM_W  = 35;   // magnitude limit before the scaling products
  localparam int unsigned DNORM_W = 40;   // divisor limit before the gain product
  localparam int unsigned PROD_W  = 59;
  localparam int unsigned GAIN_W  = 21;
  localparam int unsigned GAINP_W = DNORM_W + GAIN_W;
  localparam int unsigned KW      = 4;
  localparam int unsigned EB0_W   = 5;
  localparam int unsigned EXP_W   = 8;
  localparam int unsigned POS_W   = 6;

  localparam int unsigned SLOPE_W  = 15;
  localparam int unsigned ASPECT_W = 17;

  localparam logic [GAIN_W-1:0] GAIN = 21'd1726753;

  localparam logic signed [ZW-1:0] DEG90   = 34'sd1509949440;
  localparam logic signed [AW-1:0] DEG90_A  = 36'sd1509949440;
  localparam logic signed [AW-1:0] DEG180_A = 36'sd3019898880;
  localparam logic signed [AW-1:0] DEG360_A = 36'sd6039797760;
  localparam int unsigned Q8_SHIFT = 16;

  localparam logic [29:0] ATAN_TAB [ITERS] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
    30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
    30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EW_KERNEL = 3'd0,
    REG_NS_KERNEL = 3'd1,
    REG_EW_RES    = 3'd2,
    REG_NS_RES    = 3'd3,
    REG_SMOOTH    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [KER_W-1:0] ew_kernel;
    logic [KER_W-1:0] ns_kernel;
    logic [RES_W-1:0] ew_res;
    logic [RES_W-1:0] ns_res;
    logic [SM_W-1:0]  smooth;
  } cfg_t;

  typedef struct packed {
    logic flat;
    logic sx_zero;
    logic sx_neg;
    logic sy_neg;
  } flags_t;

  // Travels beside the first CORDIC row.
  typedef struct packed {
    flags_t                  flags;
    logic [KW-1:0]           k;
    logic signed [EXP_W-1:0] eb;
    logic [MANT_W-1:0]       mb;
  } side1_t;

  // Travels beside the second CORDIC row.
  typedef struct packed {
    logic                flat;
    logic [ASPECT_W-1:0] aspect;
  } side2_t;

  function automatic logic [POS_W-1:0] msb_pos(input logic [63:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

endpackage

>>> hdl/tsa_in_if.sv
interface tsa_in_if #(
  parameter int unsigned ELEV_WIDTH = tsa_pkg::ELEV_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEV_WIDTH-1:0] elev_0;
  logic signed [ELEV_WIDTH-1:0] elev_1;
  logic signed [ELEV_WIDTH-1:0] elev_2;
  logic signed [ELEV_WIDTH-1:0] elev_3;
  logic signed [ELEV_WIDTH-1:0] elev_4;
  logic signed [ELEV_WIDTH-1:0] elev_5;
  logic signed [ELEV_WIDTH-1:0] elev_6;
  logic signed [ELEV_WIDTH-1:0] elev_7;
  logic signed [ELEV_WIDTH-1:0] elev_8;

  modport source (
    output valid, elev_0, elev_1, elev_2, elev_3, elev_4, elev_5, elev_6, elev_7, elev_8,
    input  ready
  );
  modport sink (
    input  valid, elev_0, elev_1, elev_2, elev_3, elev_4, elev_5, elev_6, elev_7, elev_8,
    output ready
  );
endinterface

>>> hdl/tsa_out_if.sv
interface tsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [tsa_pkg::SLOPE_W-1:0]   slope_deg;
  logic [tsa_pkg::ASPECT_W-1:0]  aspect_deg;

  modport source (output valid, slope_deg, aspect_deg, input ready);
  modport sink (input valid, slope_deg, aspect_deg, output ready);
endinterface

>>> hdl/tsa_cordic_cell.sv
module tsa_cordic_cell #(
  parameter int unsigned STAGE  = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [tsa_pkg::DP_W-1:0]   x_i,
  input  logic signed [tsa_pkg::DP_W-1:0]   y_i,
  input  logic signed [tsa_pkg::ZW-1:0]     z_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [tsa_pkg::DP_W-1:0]   x_o,
  output logic signed [tsa_pkg::DP_W-1:0]   y_o,
  output logic signed [tsa_pkg::ZW-1:0]     z_o,
  output logic [SIDE_W-1:0]                 side_o
);

  logic                            valid_q;
  logic signed [tsa_pkg::DP_W-1:0] x_d, y_d, x_q, y_q, dx, dy;
  logic signed [tsa_pkg::ZW-1:0]   z_d, z_q, ang;
  logic [SIDE_W-1:0]               side_q;

  assign ang = $signed(tsa_pkg::ZW'(tsa_pkg::ATAN_TAB[STAGE]));

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    // Rotate towards the x axis; the sign of y picks the direction.
    if (!y_i[tsa_pkg::DP_W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ang;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

>>> hdl/tsa_prep.sv
module tsa_prep #(
  parameter int unsigned ELEV_WIDTH = tsa_pkg::ELEV_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH = tsa_pkg::COEF_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [ELEV_WIDTH-1:0]    elev_i [tsa_pkg::NTAPS],
  input  tsa_pkg::cfg_t                   cfg_i,
  output logic                            valid_o,
  output logic signed [tsa_pkg::DP_W-1:0] p_o,
  output logic signed [tsa_pkg::DP_W-1:0] q_o,
  output tsa_pkg::side1_t                 side_o
);

  localparam int unsigned PW = ELEV_WIDTH + COEF_WIDTH;
  localparam int unsigned SW = PW + 4;
  localparam int unsigned DW = 2*tsa_pkg::RES_W + tsa_pkg::SM_W;

  // Stage A: tap products and resolution product.
  logic                 va_q;
  logic signed [PW-1:0] px_d [tsa_pkg::NTAPS];
  logic signed [PW-1:0] py_d [tsa_pkg::NTAPS];
  logic signed [PW-1:0] px_q [tsa_pkg::NTAPS];
  logic signed [PW-1:0] py_q [tsa_pkg::NTAPS];
  logic [tsa_pkg::RES_W-1:0]   rx, ry, rxa_q, rya_q;
  logic [tsa_pkg::SM_W-1:0]    sm, sma_q;
  logic [2*tsa_pkg::RES_W-1:0] rr_q;

  // Stage B: window sums and full divisor.
  logic                 vb_q;
  logic signed [SW-1:0] sx_d, sy_d, sx_q, sy_q;
  logic [tsa_pkg::RES_W-1:0]              rxb_q, ryb_q;
  logic [DW-1:0]                          d_q;

  // Stage C: magnitudes brought under the product limit.
  logic                   vc_q;
  logic [SW-1:0]          ax, ay, axy;
  logic [tsa_pkg::KW-1:0] k_d, kc_q;
  logic [tsa_pkg::NORM_W-1:0]  axs_q, ays_q;
  logic [tsa_pkg::EB0_W-1:0]   e0_d, e0c_q;
  logic [tsa_pkg::DNORM_W-1:0] ds_q;
  tsa_pkg::flags_t        fl_d, flc_q;
  logic [tsa_pkg::RES_W-1:0]   rxc_q, ryc_q;

  // Stage D: scaled vector and divisor times gain.
  logic                         vd_q;
  logic [tsa_pkg::PROD_W-1:0]   pd_q, qd_q;
  logic [tsa_pkg::GAINP_W-1:0]  mb0d_q;
  logic [tsa_pkg::KW-1:0]       kd_q;
  logic [tsa_pkg::EB0_W-1:0]    e0d_q;
  tsa_pkg::flags_t              fld_q;

  // Stage E: leading one of the divisor mantissa.
  logic                         ve_q;
  logic [tsa_pkg::PROD_W-1:0]   pe_q, qe_q;
  logic [tsa_pkg::GAINP_W-1:0]  mb0e_q;
  logic [tsa_pkg::POS_W-1:0]    pose_q;
  logic [tsa_pkg::KW-1:0]       ke_q;
  logic [tsa_pkg::EB0_W-1:0]    e0e_q;
  tsa_pkg::flags_t              fle_q;

  // Stage F: normalised divisor mantissa.
  logic                         vf_q;
  logic [tsa_pkg::MANT_W-1:0]   mb_d;
  logic signed [tsa_pkg::EXP_W-1:0] eb_d;
  logic [tsa_pkg::PROD_W-1:0]   pf_q, qf_q;
  tsa_pkg::side1_t              sf_q;

  always_comb begin
    rx = (cfg_i.ew_res == '0) ? tsa_pkg::RES_W'(1) : cfg_i.ew_res;
    ry = (cfg_i.ns_res == '0) ? tsa_pkg::RES_W'(1) : cfg_i.ns_res;
    sm = (cfg_i.smooth == '0) ? tsa_pkg::SM_W'(1) : cfg_i.smooth;
    for (int t = 0; t < tsa_pkg::NTAPS; t++) begin
      px_d[t] = elev_i[t] * $signed(cfg_i.ew_kernel[t*COEF_WIDTH +: COEF_WIDTH]);
      py_d[t] = elev_i[t] * $signed(cfg_i.ns_kernel[t*COEF_WIDTH +: COEF_WIDTH]);
    end
  end

  always_comb begin
    sx_d = '0;
    sy_d = '0;
    for (int t = 0; t < tsa_pkg::NTAPS; t++) begin
      sx_d = sx_d + SW'(px_q[t]);
      sy_d = sy_d + SW'(py_q[t]);
    end
  end

  always_comb begin
    ax  = sx_q[SW-1] ? SW'(-sx_q) : SW'(sx_q);
    ay  = sy_q[SW-1] ? SW'(-sy_q) : SW'(sy_q);
    axy = ax | ay;
    k_d = '0;
    for (int i = tsa_pkg::NORM_W; i < SW; i++) begin
      if (axy[i]) k_d = tsa_pkg::KW'(i - tsa_pkg::NORM_W + 1);
    end
    e0_d = '0;
    for (int i = tsa_pkg::DNORM_W; i < DW; i++) begin
      if (d_q[i]) e0_d = tsa_pkg::EB0_W'(i - tsa_pkg::DNORM_W + 1);
    end
    fl_d.flat    = (sx_q == '0) && (sy_q == '0);
    fl_d.sx_zero = (sx_q == '0);
    fl_d.sx_neg  = sx_q[SW-1];
    fl_d.sy_neg  = sy_q[SW-1];
  end

  always_comb begin
    if (pose_q >= tsa_pkg::POS_W'(tsa_pkg::MANT_MSB)) begin
      mb_d = tsa_pkg::MANT_W'(mb0e_q >> (pose_q - tsa_pkg::POS_W'(tsa_pkg::MANT_MSB)));
    end else begin
      mb_d = tsa_pkg::MANT_W'(mb0e_q << (tsa_pkg::POS_W'(tsa_pkg::MANT_MSB) - pose_q));
    end
    // Exponent: right shifts taken, minus the gain's 20 fraction bits, plus normalising shift.
    eb_d = $signed({3'b000, e0e_q}) - tsa_pkg::EXP_W'(20 + tsa_pkg::MANT_MSB)
         + $signed({2'b00, pose_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= px_d;
      py_q   <= py_d;
      rxa_q  <= rx;
      rya_q  <= ry;
      sma_q  <= sm;
      rr_q   <= (2*tsa_pkg::RES_W)'(rx) * (2*tsa_pkg::RES_W)'(ry);

      sx_q   <= sx_d;
      sy_q   <= sy_d;
      rxb_q  <= rxa_q;
      ryb_q  <= rya_q;
      d_q    <= DW'(rr_q) * DW'(sma_q);

      kc_q   <= k_d;
      axs_q  <= tsa_pkg::NORM_W'(ax >> k_d);
      ays_q  <= tsa_pkg::NORM_W'(ay >> k_d);
      e0c_q  <= e0_d;
      ds_q   <= tsa_pkg::DNORM_W'(d_q >> e0_d);
      flc_q  <= fl_d;
      rxc_q  <= rxb_q;
      ryc_q  <= ryb_q;

      pd_q   <= tsa_pkg::PROD_W'(axs_q) * tsa_pkg::PROD_W'(ryc_q);
      qd_q   <= tsa_pkg::PROD_W'(ays_q) * tsa_pkg::PROD_W'(rxc_q);
      mb0d_q <= tsa_pkg::GAINP_W'(ds_q) * tsa_pkg::GAINP_W'(tsa_pkg::GAIN);
      kd_q   <= kc_q;
      e0d_q  <= e0c_q;
      fld_q  <= flc_q;

      pe_q   <= pd_q;
      qe_q   <= qd_q;
      mb0e_q <= mb0d_q;
      pose_q <= tsa_pkg::msb_pos(64'(mb0d_q));
      ke_q   <= kd_q;
      e0e_q  <= e0d_q;
      fle_q  <= fld_q;

      pf_q     <= pe_q;
      qf_q     <= qe_q;
      sf_q.flags <= fle_q;
      sf_q.k   <= ke_q;
      sf_q.eb  <= eb_d;
      sf_q.mb  <= mb_d;
    end
  end

  assign valid_o = vf_q;
  assign p_o     = $signed(tsa_pkg::DP_W'(pf_q));
  assign q_o     = $signed(tsa_pkg::DP_W'(qf_q));
  assign side_o  = sf_q;

endmodule

>>> hdl/terrain_slope_aspect.sv
// Throughput: one request per cycle; every stage moves while the output register is
// empty or being taken, so the pipeline stalls as a whole only on output back-pressure.
// The depth is set by two rows of 24 CORDIC cells plus the scaling and alignment stages.
// Reset (asynchronous, active low) empties the pipeline and loads the configuration
// defaults: kernels zero, both resolutions 256, smoothing divisor 1.
module terrain_slope_aspect #(
  parameter int unsigned ELEV_WIDTH = tsa_pkg::ELEV_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH = tsa_pkg::COEF_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  tsa_in_if.sink                           in_i,
  tsa_out_if.source                        out_o
);

  localparam int unsigned N = tsa_pkg::ITERS;

  tsa_pkg::cfg_t cfg_q;
  logic          en;
  logic          out_v_q;
  logic [tsa_pkg::SLOPE_W-1:0]  slope_q;
  logic [tsa_pkg::ASPECT_W-1:0] aspect_q;

  logic signed [ELEV_WIDTH-1:0] elev [tsa_pkg::NTAPS];

  assign en       = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  assign elev[0] = in_i.elev_0;
  assign elev[1] = in_i.elev_1;
  assign elev[2] = in_i.elev_2;
  assign elev[3] = in_i.elev_3;
  assign elev[4] = in_i.elev_4;
  assign elev[5] = in_i.elev_5;
  assign elev[6] = in_i.elev_6;
  assign elev[7] = in_i.elev_7;
  assign elev[8] = in_i.elev_8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ew_kernel <= '0;
      cfg_q.ns_kernel <= '0;
      cfg_q.ew_res    <= tsa_pkg::RES_W'(256);
      cfg_q.ns_res    <= tsa_pkg::RES_W'(256);
      cfg_q.smooth    <= tsa_pkg::SM_W'(1);
    end else if (cfg_we_i) begin
      unique case (tsa_pkg::cfg_reg_e'(cfg_idx_i))
        tsa_pkg::REG_EW_KERNEL: cfg_q.ew_kernel <= cfg_data_i;
        tsa_pkg::REG_NS_KERNEL: cfg_q.ns_kernel <= cfg_data_i;
        tsa_pkg::REG_EW_RES:    cfg_q.ew_res    <= cfg_data_i[tsa_pkg::RES_W-1:0];
        tsa_pkg::REG_NS_RES:    cfg_q.ns_res    <= cfg_data_i[tsa_pkg::RES_W-1:0];
        tsa_pkg::REG_SMOOTH:    cfg_q.smooth    <= cfg_data_i[tsa_pkg::SM_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: weighting, scaling and divisor preparation.
  logic                            c1_v [N+1];
  logic signed [tsa_pkg::DP_W-1:0] c1_x [N+1];
  logic signed [tsa_pkg::DP_W-1:0] c1_y [N+1];
  logic signed [tsa_pkg::ZW-1:0]   c1_z [N+1];
  tsa_pkg::side1_t                 c1_s [N+1];

  tsa_prep #(
    .ELEV_WIDTH (ELEV_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .elev_i  (elev),
    .cfg_i   (cfg_q),
    .valid_o (c1_v[0]),
    .p_o     (c1_x[0]),
    .q_o     (c1_y[0]),
    .side_o  (c1_s[0])
  );
  assign c1_z[0] = '0;

  // First row: direction of the gradient vector.
  for (genvar i = 0; i < N; i++) begin : g_row1
    tsa_cordic_cell #(
      .STAGE  (i),
      .SIDE_W ($bits(tsa_pkg::side1_t))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c1_v[i]),
      .x_i     (c1_x[i]),
      .y_i     (c1_y[i]),
      .z_i     (c1_z[i]),
      .side_i  (c1_s[i]),
      .valid_o (c1_v[i+1]),
      .x_o     (c1_x[i+1]),
      .y_o     (c1_y[i+1]),
      .z_o     (c1_z[i+1]),
      .side_o  (c1_s[i+1])
    );
  end

  // M1: clamp the direction angle, locate the magnitude's leading one.
  logic                              m1_v_q;
  logic signed [tsa_pkg::ZW-1:0]     theta_d, theta_q;
  logic [tsa_pkg::DP_W-1:0]          mag_q;
  logic [tsa_pkg::POS_W-1:0]         mpos_q;
  tsa_pkg::side1_t                   m1_s_q;

  always_comb begin
    if (c1_z[N] < 0) begin
      theta_d = '0;
    end else if (c1_z[N] > tsa_pkg::DEG90) begin
      theta_d = tsa_pkg::DEG90;
    end else begin
      theta_d = c1_z[N];
    end
  end

  // M2: aspect and normalised magnitude.
  logic                              m2_v_q;
  logic signed [tsa_pkg::AW-1:0]     at, sg90, asp_raw, asp;
  logic [tsa_pkg::ASPECT_W-1:0]      asp_q8;
  logic [tsa_pkg::MANT_W-1:0]        ma_d, ma_q, mb2_q;
  logic signed [tsa_pkg::EXP_W-1:0]  ea_d, ea_q, eb2_q;
  tsa_pkg::side2_t                   m2_s_q;

  always_comb begin
    if (m1_s_q.flags.sx_zero) begin
      at   = m1_s_q.flags.sy_neg ? -tsa_pkg::DEG90_A : tsa_pkg::DEG90_A;
      sg90 = '0;
    end else begin
      at   = (m1_s_q.flags.sx_neg != m1_s_q.flags.sy_neg) ?
             -tsa_pkg::AW'(theta_q) : tsa_pkg::AW'(theta_q);
      sg90 = m1_s_q.flags.sx_neg ? -tsa_pkg::DEG90_A : tsa_pkg::DEG90_A;
    end
    asp_raw = tsa_pkg::DEG180_A - at + sg90;
    if (asp_raw < 0) begin
      asp = '0;
    end else if (asp_raw > tsa_pkg::DEG360_A) begin
      asp = tsa_pkg::DEG360_A;
    end else begin
      asp = asp_raw;
    end
    asp_q8 = tsa_pkg::ASPECT_W'((asp + (tsa_pkg::AW'(1) << (tsa_pkg::Q8_SHIFT - 1)))
                                >>> tsa_pkg::Q8_SHIFT);

    // A zero magnitude keeps the bare exponent k + 8.
    ea_d = $signed({4'b0000, m1_s_q.k}) + tsa_pkg::EXP_W'(8);
    if (mag_q == '0) begin
      ma_d = '0;
    end else begin
      ea_d = ea_d + $signed({2'b00, mpos_q}) - tsa_pkg::EXP_W'(tsa_pkg::MANT_MSB);
      if (mpos_q >= tsa_pkg::POS_W'(tsa_pkg::MANT_MSB)) begin
        ma_d = tsa_pkg::MANT_W'(mag_q >> (mpos_q - tsa_pkg::POS_W'(tsa_pkg::MANT_MSB)));
      end else begin
        ma_d = tsa_pkg::MANT_W'(mag_q << (tsa_pkg::POS_W'(tsa_pkg::MANT_MSB) - mpos_q));
      end
    end
  end

  // M3: align the two mantissas on the larger exponent.
  logic signed [tsa_pkg::EXP_W-1:0]  dexp;
  logic [tsa_pkg::EXP_W-1:0]         ndexp;
  logic [tsa_pkg::MANT_W-1:0]        ma_al, mb_al;

  always_comb begin
    dexp  = ea_q - eb2_q;
    ndexp = tsa_pkg::EXP_W'(-dexp);
    ma_al = ma_q;
    mb_al = mb2_q;
    if (dexp > 0) begin
      mb_al = mb2_q >> dexp[tsa_pkg::EXP_W-2:0];
    end else if (dexp < 0) begin
      ma_al = ma_q >> ndexp[tsa_pkg::EXP_W-2:0];
    end
  end

  logic                            c2_v [N+1];
  logic signed [tsa_pkg::DP_W-1:0] c2_x [N+1];
  logic signed [tsa_pkg::DP_W-1:0] c2_y [N+1];
  logic signed [tsa_pkg::ZW-1:0]   c2_z [N+1];
  tsa_pkg::side2_t                 c2_s [N+1];
  logic                            m3_v_q;
  logic [tsa_pkg::MANT_W-1:0]      ma3_q, mb3_q;
  tsa_pkg::side2_t                 m3_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= c1_v[N];
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      theta_q <= theta_d;
      mag_q   <= c1_x[N];
      mpos_q  <= tsa_pkg::msb_pos(64'(c1_x[N]));
      m1_s_q  <= c1_s[N];

      ma_q          <= ma_d;
      ea_q          <= ea_d;
      mb2_q         <= m1_s_q.mb;
      eb2_q         <= m1_s_q.eb;
      m2_s_q.flat   <= m1_s_q.flags.flat;
      m2_s_q.aspect <= asp_q8;

      ma3_q  <= ma_al;
      mb3_q  <= mb_al;
      m3_s_q <= m2_s_q;
    end
  end

  assign c2_v[0] = m3_v_q;
  assign c2_x[0] = $signed(tsa_pkg::DP_W'(mb3_q));
  assign c2_y[0] = $signed(tsa_pkg::DP_W'(ma3_q));
  assign c2_z[0] = '0;
  assign c2_s[0] = m3_s_q;

  // Second row: slope angle from magnitude over divisor.
  for (genvar i = 0; i < N; i++) begin : g_row2
    tsa_cordic_cell #(
      .STAGE  (i),
      .SIDE_W ($bits(tsa_pkg::side2_t))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c2_v[i]),
      .x_i     (c2_x[i]),
      .y_i     (c2_y[i]),
      .z_i     (c2_z[i]),
      .side_i  (c2_s[i]),
      .valid_o (c2_v[i+1]),
      .x_o     (c2_x[i+1]),
      .y_o     (c2_y[i+1]),
      .z_o     (c2_z[i+1]),
      .side_o  (c2_s[i+1])
    );
  end

  logic signed [tsa_pkg::ZW-1:0] slope_c;
  logic [tsa_pkg::SLOPE_W-1:0]   slope_q8;

  always_comb begin
    if (c2_z[N] < 0) begin
      slope_c = '0;
    end else if (c2_z[N] > tsa_pkg::DEG90) begin
      slope_c = tsa_pkg::DEG90;
    end else begin
      slope_c = c2_z[N];
    end
    slope_q8 = tsa_pkg::SLOPE_W'((slope_c + (tsa_pkg::ZW'(1) << (tsa_pkg::Q8_SHIFT - 1)))
                                 >>> tsa_pkg::Q8_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= c2_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // A flat window gives zero for both angles.
      slope_q  <= c2_s[N].flat ? '0 : slope_q8;
      aspect_q <= c2_s[N].flat ? '0 : c2_s[N].aspect;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.slope_deg  = slope_q;
  assign out_o.aspect_deg = aspect_q;

endmodule

>>> hdl/tsa_checker.sv
`include "terrain_slope_aspect_defines.svh"

module tsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [tsa_pkg::SLOPE_W-1:0]   slope_i,
  input logic [tsa_pkg::ASPECT_W-1:0]  aspect_i
);

  // A result that is not taken stays put.
  `TSA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(slope_i) && $stable(aspect_i))

  // Slope never exceeds ninety degrees.
  `TSA_ASSERT(a_slope_range, clk_i, rst_ni, out_valid_i |-> slope_i <= 15'd23040)

  // Aspect never exceeds a full turn.
  `TSA_ASSERT(a_aspect_range, clk_i, rst_ni, out_valid_i |-> aspect_i <= 17'd92160)

  // Reset empties the pipeline.
  `TSA_ASSERT_NR(a_reset_empty, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind terrain_slope_aspect tsa_checker u_tsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .slope_i     (out_o.slope_deg),
  .aspect_i    (out_o.aspect_deg)
);
